[rtl/core/hlsc_pkg.sv]
// hlsc_pkg: request, result, command and status types for the hashed LRU slot cache.
// Shared by hlsc_ctrl, hlsc_dp and hashed_lru_slot_cache_unit; depends on nothing.
package hlsc_pkg;

	localparam int HASH_W = 64;
	localparam int KEY_W  = 64;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 5;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_FLUSH  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [HASH_W-1:0] lookup_hash;
		logic [KEY_W-1:0]  lookup_key;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              evicted;
		logic [CNT_W-1:0]  collisions;
		logic [CNT_W-1:0]  released_count;
	} rsp_t;

	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic cmp;
		logic scan;
		logic write;
		logic pop;
		logic flush_done;
	} cmd_t;

	typedef struct packed {
		logic active_zero;
	} stat_t;

endpackage

[rtl/core/hlsc_ctrl.sv]
// hlsc_ctrl: sequencing state machine of the slot cache; drives datapath commands.
// Depends on hlsc_pkg.
module hlsc_ctrl import hlsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  logic  func,
	output logic  req_stall,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_WRITE,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.cfg_wr     = cfg_valid && cfg_ready;
		cmd.load       = req_valid && !req_stall;
		cmd.cmp        = (state_q == ST_CMP);
		cmd.scan       = (state_q == ST_SCAN);
		cmd.write      = (state_q == ST_WRITE) && out_free;
		cmd.pop        = (state_q == ST_FLUSH) && !stat.active_zero;
		cmd.flush_done = (state_q == ST_FLUSH) && stat.active_zero && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write || cmd.flush_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= (func == FUNC_FLUSH) ? ST_FLUSH : ST_CMP;
					end
				end
				ST_CMP:   state_q <= ST_SCAN;
				ST_SCAN:  state_q <= ST_WRITE;
				ST_WRITE: begin
					if (cmd.write) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (cmd.flush_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/hlsc_dp.sv]
// hlsc_dp: slot tags, recency order, free stack, per-slot comparators and result register.
// Depends on hlsc_pkg; commanded by hlsc_ctrl.
module hlsc_dp import hlsc_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  req_t             req,
	input  logic [CNT_W-1:0] cfg_data,
	output stat_t            stat,
	output logic [$clog2(SLOTS+1)-1:0] active_cnt,
	output logic [$clog2(SLOTS+1)-1:0] free_cnt,
	output rsp_t             rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [HASH_W-1:0] req_hash_q;
	logic [KEY_W-1:0]  req_key_q;
	logic [HASH_W-1:0] slot_hash_q [SLOTS];
	logic [KEY_W-1:0]  slot_key_q  [SLOTS];
	logic [IW-1:0]     order_q     [SLOTS];
	logic [IW-1:0]     stack_q     [SLOTS];
	logic [CW-1:0]     active_q;
	logic [CW-1:0]     fc_q;
	logic [SLOTS-1:0]  amask_q;
	logic [CW-1:0]     rel_q;
	rsp_t              rsp_q;

	logic [SLOTS-1:0]  heq_s1;
	logic [SLOTS-1:0]  keq_s1;

	logic              hit_s2;
	logic [IW-1:0]     hslot_s2;
	logic [CW-1:0]     coll_s2;
	logic [SLOTS-1:0]  shift_s2;

	logic [SLOTS-1:0]  full_v;
	logic [SLOTS-1:0]  coll_v;
	logic [SLOTS-1:0]  pos_hit;
	logic [SLOTS-1:0]  pos_coll;
	logic [SLOTS-1:0]  below;
	logic [CW-1:0]     coll_cnt;
	logic [IW-1:0]     hit_enc;
	logic [CW-1:0]     evict_pos;
	logic              evict;
	logic [IW-1:0]     new_slot;
	logic [CW-1:0]     cfg_v;

	assign stat.active_zero = (active_q == '0);
	assign active_cnt       = active_q;
	assign free_cnt         = fc_q;
	assign rsp              = rsp_q;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_v = CW'(1);
		end else if (int'(cfg_data) > SLOTS) begin
			cfg_v = CW'(SLOTS);
		end else begin
			cfg_v = CW'(cfg_data);
		end
	end

	always_comb begin
		full_v   = heq_s1 & keq_s1 & amask_q;
		coll_v   = heq_s1 & ~keq_s1 & amask_q;
		hit_enc  = '0;
		coll_cnt = '0;
		for (int i = 0; i < SLOTS; i++) begin
			pos_hit[i]  = (CW'(i) < active_q) && full_v[order_q[i]];
			pos_coll[i] = (CW'(i) < active_q) && coll_v[order_q[i]];
			if (full_v[i]) begin
				hit_enc = hit_enc | IW'(i);
			end
		end
		below = (pos_hit != '0) ? (pos_hit - SLOTS'(1)) : '1;
		for (int i = 0; i < SLOTS; i++) begin
			coll_cnt = coll_cnt + CW'(pos_coll[i] & below[i]);
		end
	end

	always_comb begin
		evict     = (fc_q == '0);
		evict_pos = active_q - CW'(1);
		if (hit_s2) begin
			new_slot = hslot_s2;
		end else if (evict) begin
			new_slot = order_q[evict_pos[IW-1:0]];
		end else begin
			new_slot = stack_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			fc_q     <= CW'(SLOTS);
			amask_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				stack_q[i] <= IW'(SLOTS - 1 - i);
			end
		end else if (cmd.cfg_wr) begin
			active_q <= '0;
			fc_q     <= cfg_v;
			amask_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				stack_q[i] <= IW'(cfg_v - CW'(1) - CW'(i));
			end
		end else if (cmd.write && !hit_s2) begin
			amask_q[new_slot] <= 1'b1;
			if (!evict) begin
				fc_q     <= fc_q - CW'(1);
				active_q <= active_q + CW'(1);
				for (int i = 0; i < SLOTS - 1; i++) begin
					stack_q[i] <= stack_q[i+1];
				end
			end
		end else if (cmd.pop) begin
			amask_q[order_q[0]] <= 1'b0;
			fc_q     <= fc_q + CW'(1);
			active_q <= active_q - CW'(1);
			stack_q[0] <= order_q[0];
			for (int i = 1; i < SLOTS; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_hash_q <= req.lookup_hash;
			req_key_q  <= req.lookup_key;
			rel_q      <= active_q;
		end
		if (cmd.cmp) begin
			for (int i = 0; i < SLOTS; i++) begin
				heq_s1[i] <= (slot_hash_q[i] == req_hash_q);
				keq_s1[i] <= (slot_key_q[i] == req_key_q);
			end
		end
		if (cmd.scan) begin
			hit_s2   <= (pos_hit != '0);
			hslot_s2 <= hit_enc;
			coll_s2  <= coll_cnt;
			shift_s2 <= (pos_hit != '0) ? (pos_hit | below) : '1;
		end
		if (cmd.write) begin
			for (int j = 1; j < SLOTS; j++) begin
				if (shift_s2[j]) begin
					order_q[j] <= order_q[j-1];
				end
			end
			order_q[0] <= new_slot;
			if (!hit_s2) begin
				slot_hash_q[new_slot] <= req_hash_q;
				slot_key_q[new_slot]  <= req_key_q;
			end
			rsp_q.slot           <= SLOT_W'(new_slot);
			rsp_q.hit            <= hit_s2;
			rsp_q.evicted        <= !hit_s2 && evict;
			rsp_q.collisions     <= CNT_W'(coll_s2);
			rsp_q.released_count <= '0;
		end else if (cmd.pop) begin
			for (int j = 0; j < SLOTS - 1; j++) begin
				order_q[j] <= order_q[j+1];
			end
		end else if (cmd.flush_done) begin
			rsp_q.slot           <= '0;
			rsp_q.hit            <= 1'b0;
			rsp_q.evicted        <= 1'b0;
			rsp_q.collisions     <= '0;
			rsp_q.released_count <= CNT_W'(rel_q);
		end
	end

endmodule

[rtl/core/hashed_lru_slot_cache_unit.sv]
// hashed_lru_slot_cache_unit: top level of the fully associative LRU slot cache.
// Instantiates hlsc_ctrl and hlsc_dp; depends on hlsc_pkg.
//
// Request channel (req_valid, req_stall, req): func selects a lookup of the
// given 64-bit hash and key or a flush of all active slots. A request is taken
// when req_valid is high and req_stall low; one request is worked on at a time.
// Response channel (rsp_valid, rsp_stall, rsp): one response per request, held
// in an output register until taken, so the next request may enter while it
// waits.
// A lookup takes these steps before it reaches the response register: compare
// all slot tags in parallel, rank matches by recency and count collisions,
// then update order, free stack and tags; the block then returns to idle for
// the next request. A flush pushes the active slots back to the free stack,
// one slot per cycle, and then writes the response register.
// Configuration (cfg_valid, cfg_ready, cfg_data): writing slots_in_use empties
// the cache and rebuilds the free stack; accepted only when idle.
// Reset: all SLOTS slots free, cache empty, no response pending.
// A stalled response holds the block at its final step until taken.
module hashed_lru_slot_cache_unit import hlsc_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int CW = $clog2(SLOTS + 1);

	cmd_t          cmd;
	stat_t         stat;
	logic [CW-1:0] active_cnt;
	logic [CW-1:0] free_cnt;

	hlsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.func      (req.func),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hlsc_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req        (req),
		.cfg_data   (cfg_data),
		.stat       (stat),
		.active_cnt (active_cnt),
		.free_cnt   (free_cnt),
		.rsp        (rsp)
	);

	a_cfg_req_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && req_valid && !req_stall))
		else $error("configuration write and request taken together");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.hit) |-> (!rsp.evicted && rsp.released_count == '0))
		else $error("hit response carries eviction or release count");

	a_slot_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(active_cnt) + int'(free_cnt)) <= SLOTS)
		else $error("active and free slots exceed slot count");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_done |=> (active_cnt == '0))
		else $error("flush left active slots");

endmodule
